// ===== rtl/rpid_pkg.sv =====
`default_nettype none

package rpid_pkg;

    // Axis and integrator sizing
    localparam int AXIS_COUNT       = 3;
    localparam int AXIS_W           = $clog2(AXIS_COUNT);
    localparam int INTEGRATOR_LIMIT = 256;
    localparam int INT_FRAC         = 13;
    localparam int INT_W            = $clog2(INTEGRATOR_LIMIT) + INT_FRAC + 2;
    localparam int ITERM_W          = INT_W - INT_FRAC;
    localparam logic signed [INT_W-1:0] INT_MAX =
        INT_W'(INTEGRATOR_LIMIT * (2 ** INT_FRAC));
    localparam logic signed [INT_W-1:0] INT_MIN = -INT_MAX;

    // Datapath widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PROD_W  = 40;
    localparam int DES_W   = 18;
    localparam int ERR_W   = 19;
    localparam int DLT_W   = ERR_W + 1;
    localparam int PT_W    = 20;
    localparam int ANG_W   = 13;
    localparam int Q10_W   = 12;
    localparam int NUM_W   = 18;
    localparam int HIST_W  = 32;
    localparam int DSUM_W  = HIST_W + 2;
    localparam int TOT_W   = 34;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Divide by ten through a reciprocal: exact for magnitudes below 2**18
    localparam logic [16:0] RECIP_TEN   = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    // Stick handling
    localparam logic signed [9:0] STICK_MAX   = 10'sd500;
    localparam logic signed [9:0] STICK_MIN   = -10'sd500;
    localparam logic [8:0]        RATE_OFFSET = 9'd27;

    // Loop time and D scaling divider
    localparam logic [15:0] DT_MIN   = 16'd16;
    localparam int          DT_SHIFT = 4;
    localparam int          QUO_W    = 16;
    localparam int          DSR_W    = 16 - DT_SHIFT;
    localparam int          CNT_W    = $clog2(QUO_W);
    localparam logic [QUO_W-1:0] DIVIDEND = 16'hFFFF;

    // Saturation bounds
    localparam logic signed [HIST_W-1:0] DLT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [HIST_W-1:0] DLT_MIN = 32'sh8000_0000;
    localparam logic signed [15:0]       DRV_MAX = 16'sh7FFF;
    localparam logic signed [15:0]       DRV_MIN = 16'sh8000;

    // Axis and mode codes
    localparam logic [1:0] AXIS_ROLL    = 2'd0;
    localparam logic [1:0] AXIS_PITCH   = 2'd1;
    localparam logic [1:0] AXIS_YAW     = 2'd2;
    localparam logic [1:0] MODE_ACRO    = 2'd0;
    localparam logic [1:0] MODE_ANGLE   = 2'd1;
    localparam logic [1:0] MODE_HORIZON = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAINS_ROLL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAINS_PITCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAINS_YAW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_GAINS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_RATES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TRIMS = 3'd5;

    // Register reset values
    localparam logic [23:0] RST_GAINS_ROLL  = 24'h171E28;
    localparam logic [23:0] RST_GAINS_PITCH = 24'h171E28;
    localparam logic [23:0] RST_GAINS_YAW   = 24'h002D55;
    localparam logic [15:0] RST_LEVEL_GAINS = 16'h0A5A;
    localparam logic [23:0] RST_STICK_RATES = 24'h000000;
    localparam logic [31:0] RST_LEVEL_TRIMS = 32'h0000_0000;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV10,
        S_STICK,
        S_LEVEL,
        S_RATEERR,
        S_PTERM,
        S_IMUL,
        S_IGAIN,
        S_IACC,
        S_DMUL,
        S_DSUM,
        S_DTERM,
        S_DRIVE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/rpid_div.sv =====
`default_nettype none

// Restoring divider: constant dividend over a 12-bit divisor, one quotient bit a cycle
module rpid_div
    import rpid_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [DSR_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quotient
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [QUO_W-1:0] r_quo;

    logic [DSR_W:0]   w_trial;
    logic             w_fit;

    // Shift in the next dividend bit and try a subtract
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(QUO_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Remainder and quotient; the quotient register starts out holding the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= DIVIDEND;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? DSR_W'(w_trial - {1'b0, r_dsr}) : DSR_W'(w_trial);
            r_quo <= {r_quo[QUO_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/rate_pid_three_axis.sv =====
`default_nettype none

// Three-axis rate PID with angle and horizon leveling. Each request carries one
// axis sample and returns one drive value for that axis. A request is taken only
// while o_in_stall is low; the 16-step bit-serial divider then forms 65535 /
// (loop_time / 16) for the D scaling, while one shared 34x18 multiplier works
// through the angle error, desired rate, P, I and D terms one product a cycle
// but for the D product, which waits for the divider. A finished result sits in
// the output register and the next request is taken meanwhile; the sequencer
// also waits at its last step if the previous result has still not been taken.
// Configuration writes are taken at any time but should be made while the block
// is idle. Per-axis integrator, previous error and D history clear on reset.
module rate_pid_three_axis
    import rpid_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // request channel
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire [1:0]            i_axis_index,
    input  wire signed [9:0]     i_stick_command,
    input  wire signed [15:0]    i_gyro_rate,
    input  wire signed [11:0]    i_attitude_angle,
    input  wire [15:0]           i_loop_time,
    input  wire [1:0]            i_flight_mode,
    // result channel
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic [1:0]           o_out_axis,
    output logic signed [15:0]   o_drive_value,
    // configuration
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_W-1:0]      i_cfg_data
);

    // Sequencer and configuration
    t_state r_state;
    t_state n_state;

    logic [23:0] r_gains_roll;
    logic [23:0] r_gains_pitch;
    logic [23:0] r_gains_yaw;
    logic [15:0] r_level_gains;
    logic [23:0] r_stick_rates;
    logic [31:0] r_level_trims;

    // Per-axis state
    logic signed [INT_W-1:0]  r_integ    [AXIS_COUNT];
    logic signed [ERR_W-1:0]  r_prev     [AXIS_COUNT];
    logic signed [HIST_W-1:0] r_hist_one [AXIS_COUNT];
    logic signed [HIST_W-1:0] r_hist_two [AXIS_COUNT];

    // Captured request
    logic [AXIS_W-1:0]   r_axis;
    logic signed [9:0]   r_stick;
    logic signed [15:0]  r_gyro;
    logic signed [11:0]  r_att;
    logic [15:0]         r_dt;
    logic [1:0]          r_mode;

    // Working registers
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ANG_W-1:0]   r_err_ang;
    logic signed [DES_W-1:0]   r_desired;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [PT_W-1:0]    r_pterm;
    logic signed [ITERM_W-1:0] r_iterm;
    logic signed [DLT_W-1:0]   r_delta_raw;
    logic signed [DSUM_W-1:0]  r_dsum;
    logic                      r_out_valid;
    logic [AXIS_W-1:0]         r_out_axis;
    logic signed [15:0]        r_drive;

    // Combinational
    logic                      w_in_accept;
    logic                      w_out_free;
    logic                      w_out_load;
    logic                      w_is_yaw;
    logic [15:0]               w_dt_clamp;
    logic [AXIS_W-1:0]         w_axis_in;
    logic [23:0]               w_gains;
    logic [7:0]                w_kp;
    logic [7:0]                w_ki;
    logic [7:0]                w_kd;
    logic [7:0]                w_rate;
    logic [8:0]                w_rate_sum;
    logic [7:0]                w_level_gain;
    logic signed [15:0]        w_trim;
    logic signed [9:0]         w_st_clamp;
    logic signed [NUM_W-1:0]   w_num;
    logic [16:0]               w_num_abs;
    logic [Q10_W-1:0]          w_q10;
    logic signed [ANG_W-1:0]   w_err_ang;
    logic signed [DES_W-1:0]   w_des_base;
    logic signed [DES_W-1:0]   w_des_add;
    logic signed [DES_W-1:0]   w_des_fin;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [DSUM_W-1:0]  w_isum;
    logic signed [INT_W-1:0]   w_integ_new;
    logic signed [PROD_W-1:0]  w_dshift;
    logic signed [HIST_W-1:0]  w_delta;
    logic signed [DSUM_W-1:0]  w_dsum;
    logic signed [TOT_W-1:0]   w_total;
    logic signed [15:0]        w_drive;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_mul_p;
    logic                      w_div_done;
    logic [QUO_W-1:0]          w_quo;

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_out_load  = (r_state == S_DRIVE) && w_out_free;

    // Request clean-up: axis three runs as yaw, short loop times clamp
    assign w_axis_in  = (i_axis_index > AXIS_YAW) ? AXIS_YAW : i_axis_index;
    assign w_dt_clamp = (i_loop_time < DT_MIN) ? DT_MIN : i_loop_time;

    // D scaling divider, started with each request
    rpid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_accept),
        .i_divisor  (w_dt_clamp[15:DT_SHIFT]),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Per-axis gain and rate selection
    assign w_is_yaw = (r_axis == AXIS_YAW);

    always_comb begin
        case (r_axis)
            AXIS_ROLL: begin
                w_gains = r_gains_roll;
                w_rate  = r_stick_rates[7:0];
            end
            AXIS_PITCH: begin
                w_gains = r_gains_pitch;
                w_rate  = r_stick_rates[15:8];
            end
            default: begin
                w_gains = r_gains_yaw;
                w_rate  = r_stick_rates[23:16];
            end
        endcase
    end

    assign w_kp         = w_gains[7:0];
    assign w_ki         = w_gains[15:8];
    assign w_kd         = w_gains[23:16];
    assign w_rate_sum   = {1'b0, w_rate} + RATE_OFFSET;
    assign w_level_gain = (r_mode == MODE_ANGLE) ? r_level_gains[7:0] : r_level_gains[15:8];
    assign w_trim       = (r_axis == AXIS_ROLL) ? r_level_trims[15:0] : r_level_trims[31:16];

    // Angle error numerator and its divide by ten toward zero
    assign w_st_clamp = (r_stick > STICK_MAX) ? STICK_MAX :
                        ((r_stick < STICK_MIN) ? STICK_MIN : r_stick);
    assign w_num      = NUM_W'(w_st_clamp) - NUM_W'(r_att) + NUM_W'(w_trim);
    assign w_num_abs  = w_num[NUM_W-1] ? 17'(-w_num) : 17'(w_num);
    assign w_q10      = r_prod[RECIP_SHIFT +: Q10_W];
    assign w_err_ang  = w_num[NUM_W-1] ? -$signed({1'b0, w_q10}) : $signed({1'b0, w_q10});

    // Desired rate and rate error
    always_comb begin
        if (w_is_yaw) begin
            w_des_base = DES_W'(r_prod >>> 5);
        end else if (r_mode != MODE_ANGLE) begin
            w_des_base = DES_W'(r_prod >>> 4);
        end else begin
            w_des_base = '0;
        end
    end

    always_comb begin
        if (w_is_yaw) begin
            w_des_add = '0;
        end else if (r_mode == MODE_ANGLE) begin
            w_des_add = DES_W'(r_prod >>> 4);
        end else if (r_mode == MODE_HORIZON) begin
            w_des_add = DES_W'(r_prod >>> 8);
        end else begin
            w_des_add = '0;
        end
    end

    assign w_des_fin = r_desired + w_des_add;
    assign w_err     = ERR_W'(w_des_fin) - ERR_W'(r_gyro);

    // Integrator update with clamp
    assign w_isum = DSUM_W'(r_integ[r_axis]) + DSUM_W'(r_prod);

    always_comb begin
        if (w_isum > DSUM_W'(INT_MAX)) begin
            w_integ_new = INT_MAX;
        end else if (w_isum < DSUM_W'(INT_MIN)) begin
            w_integ_new = INT_MIN;
        end else begin
            w_integ_new = INT_W'(w_isum);
        end
    end

    // D delta saturation and three-sample sum
    assign w_dshift = r_prod >>> 6;

    always_comb begin
        if (w_dshift > PROD_W'(DLT_MAX)) begin
            w_delta = DLT_MAX;
        end else if (w_dshift < PROD_W'(DLT_MIN)) begin
            w_delta = DLT_MIN;
        end else begin
            w_delta = HIST_W'(w_dshift);
        end
    end

    assign w_dsum = DSUM_W'(r_hist_one[r_axis]) + DSUM_W'(r_hist_two[r_axis])
                  + DSUM_W'(w_delta);

    // Final sum and output saturation
    assign w_total = TOT_W'(r_pterm) + TOT_W'(r_iterm) + TOT_W'(r_prod >>> 8);

    always_comb begin
        if (w_total > TOT_W'(DRV_MAX)) begin
            w_drive = DRV_MAX;
        end else if (w_total < TOT_W'(DRV_MIN)) begin
            w_drive = DRV_MIN;
        end else begin
            w_drive = 16'(w_total);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (w_in_accept) n_state = S_DIV10;
            S_DIV10:   n_state = S_STICK;
            S_STICK:   n_state = S_LEVEL;
            S_LEVEL:   n_state = S_RATEERR;
            S_RATEERR: n_state = S_PTERM;
            S_PTERM:   n_state = S_IMUL;
            S_IMUL:    n_state = S_IGAIN;
            S_IGAIN:   n_state = S_IACC;
            S_IACC:    n_state = S_DMUL;
            S_DMUL:    if (w_div_done) n_state = S_DSUM;
            S_DSUM:    n_state = S_DTERM;
            S_DTERM:   n_state = S_DRIVE;
            S_DRIVE:   if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Shared multiplier operand selection
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_DIV10: begin
                w_mul_a = MUL_A_W'($signed({1'b0, w_num_abs}));
                w_mul_b = MUL_B_W'($signed({1'b0, RECIP_TEN}));
            end
            S_STICK: begin
                w_mul_a = MUL_A_W'(r_stick);
                w_mul_b = MUL_B_W'($signed({1'b0, w_rate_sum}));
            end
            S_LEVEL: begin
                w_mul_a = MUL_A_W'(r_err_ang);
                w_mul_b = MUL_B_W'($signed({1'b0, w_level_gain}));
            end
            S_PTERM: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'($signed({1'b0, w_kp}));
            end
            S_IMUL: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'($signed({1'b0, r_dt}));
            end
            S_IGAIN: begin
                w_mul_a = MUL_A_W'(r_prod >>> 11);
                w_mul_b = MUL_B_W'($signed({1'b0, w_ki}));
            end
            S_DMUL: begin
                w_mul_a = MUL_A_W'(r_delta_raw);
                w_mul_b = MUL_B_W'($signed({1'b0, w_quo}));
            end
            S_DTERM: begin
                w_mul_a = MUL_A_W'(r_dsum);
                w_mul_b = MUL_B_W'($signed({1'b0, w_kd}));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // Control state, configuration and per-axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_gains_roll  <= RST_GAINS_ROLL;
            r_gains_pitch <= RST_GAINS_PITCH;
            r_gains_yaw   <= RST_GAINS_YAW;
            r_level_gains <= RST_LEVEL_GAINS;
            r_stick_rates <= RST_STICK_RATES;
            r_level_trims <= RST_LEVEL_TRIMS;
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_integ[i]    <= '0;
                r_prev[i]     <= '0;
                r_hist_one[i] <= '0;
                r_hist_two[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // register writes; unknown indexes fall through
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAINS_ROLL:  r_gains_roll  <= i_cfg_data[23:0];
                    CFG_GAINS_PITCH: r_gains_pitch <= i_cfg_data[23:0];
                    CFG_GAINS_YAW:   r_gains_yaw   <= i_cfg_data[23:0];
                    CFG_LEVEL_GAINS: r_level_gains <= i_cfg_data[15:0];
                    CFG_STICK_RATES: r_stick_rates <= i_cfg_data[23:0];
                    CFG_LEVEL_TRIMS: r_level_trims <= i_cfg_data[31:0];
                    default: ;
                endcase
            end

            // integrator and previous error
            if (r_state == S_IACC) begin
                r_integ[r_axis] <= w_integ_new;
                r_prev[r_axis]  <= r_err;
            end

            // D history shift
            if (r_state == S_DSUM) begin
                r_hist_two[r_axis] <= r_hist_one[r_axis];
                r_hist_one[r_axis] <= w_delta;
            end

            // result register
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // product holds the D term while the drive value waits for the output
        if (r_state != S_DRIVE) begin
            r_prod <= PROD_W'(w_mul_p);
        end

        if (w_in_accept) begin
            r_axis  <= w_axis_in;
            r_stick <= i_stick_command;
            r_gyro  <= i_gyro_rate;
            r_att   <= i_attitude_angle;
            r_dt    <= w_dt_clamp;
            r_mode  <= i_flight_mode;
        end

        case (r_state)
            S_STICK:   r_err_ang <= w_err_ang;
            S_LEVEL:   r_desired <= w_des_base;
            S_RATEERR: r_err     <= w_err;
            S_IMUL:    r_pterm   <= PT_W'(r_prod >>> 7);
            S_IACC: begin
                r_iterm     <= ITERM_W'(w_integ_new >>> INT_FRAC);
                r_delta_raw <= DLT_W'(r_err) - DLT_W'(r_prev[r_axis]);
            end
            S_DSUM:    r_dsum    <= w_dsum;
            default: ;
        endcase

        if (w_out_load) begin
            r_out_axis <= r_axis;
            r_drive    <= w_drive;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_axis    = r_out_axis;
    assign o_drive_value = r_drive;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
    import rpid_pkg::*;

    // Encodings the block folds onto yaw and acro
    localparam logic [1:0] AXIS_AS_YAW  = 2'd3;
    localparam logic [1:0] MODE_AS_ACRO = 2'd3;
    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int BLOCK_ITEMS  = 100;
    localparam int BLOCK_COUNT  = 6;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT  = 200;

    typedef struct packed {
        logic [1:0]          axis;
        logic signed [15:0]  drive;
    } drive_t;

    // Tracks the per-axis PID state and the drive values still owed by the block
    class drive_checker;
        logic [23:0] axis_gains [3];
        logic [15:0] level_gains;
        logic [23:0] stick_rates;
        logic [31:0] level_trims;
        longint      integ [3];
        longint      last_err [3];
        longint      hist_one [3];
        longint      hist_two [3];
        drive_t      expected_drives [$];
        int          errors;

        function new();
            axis_gains[0] = RST_GAINS_ROLL;
            axis_gains[1] = RST_GAINS_PITCH;
            axis_gains[2] = RST_GAINS_YAW;
            level_gains   = RST_LEVEL_GAINS;
            stick_rates   = RST_STICK_RATES;
            level_trims   = RST_LEVEL_TRIMS;
            for (int a = 0; a < 3; a++) begin
                integ[a]    = 0;
                last_err[a] = 0;
                hist_one[a] = 0;
                hist_two[a] = 0;
            end
            errors = 0;
        endfunction

        function longint clamp(input longint x, input longint lo, input longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("mismatch: %s", msg);
        endtask

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                CFG_GAINS_ROLL:  axis_gains[0] = data[23:0];
                CFG_GAINS_PITCH: axis_gains[1] = data[23:0];
                CFG_GAINS_YAW:   axis_gains[2] = data[23:0];
                CFG_LEVEL_GAINS: level_gains   = data[15:0];
                CFG_STICK_RATES: stick_rates   = data[23:0];
                CFG_LEVEL_TRIMS: level_trims   = data;
                default: ;
            endcase
        endfunction

        // Work out the drive value for one accepted request and queue it
        function void note_sample(input logic [1:0] ax, input logic signed [9:0] stick,
                                  input logic signed [15:0] gyro,
                                  input logic signed [11:0] ang,
                                  input logic [15:0] loop_us, input logic [1:0] mode);
            int     a;
            longint dt, kp, ki, kd, st, rr, desired, err_ang, rate_err;
            longint pterm, iterm, delta, dsum, dterm, drv;
            drive_t exp_d;

            a  = (ax == AXIS_AS_YAW) ? 2 : int'(ax);
            dt = (loop_us < DT_MIN) ? longint'(DT_MIN) : longint'(loop_us);
            kp = longint'(axis_gains[a][7:0]);
            ki = longint'(axis_gains[a][15:8]);
            kd = longint'(axis_gains[a][23:16]);
            st = longint'(stick);

            // desired rate: stick for yaw and acro, angle error for angle mode, both for horizon
            if (a == 2) begin
                rr = longint'(stick_rates[23:16]);
                desired = ((rr + longint'(RATE_OFFSET)) * st) >>> 5;
            end else begin
                err_ang = (clamp(st, longint'(STICK_MIN), longint'(STICK_MAX))
                           - longint'(ang)
                           + longint'($signed(level_trims[16*a +: 16]))) / 10;
                if (mode == MODE_ANGLE) begin
                    desired = (err_ang * longint'(level_gains[7:0])) >>> 4;
                end else begin
                    rr = longint'(stick_rates[8*a +: 8]);
                    desired = ((rr + longint'(RATE_OFFSET)) * st) >>> 4;
                    if (mode == MODE_HORIZON)
                        desired += (err_ang * longint'(level_gains[15:8])) >>> 8;
                end
            end

            rate_err = desired - longint'(gyro);
            pterm    = (rate_err * kp) >>> 7;

            // dt-scaled integrator, clamped after each update
            integ[a] = clamp(integ[a] + ((rate_err * dt) >>> 11) * ki,
                             longint'(INT_MIN), longint'(INT_MAX));
            iterm    = integ[a] >>> INT_FRAC;

            // dt-corrected delta summed over the last three samples
            delta       = rate_err - last_err[a];
            last_err[a] = rate_err;
            delta = (delta * (longint'(DIVIDEND) / (dt >>> DT_SHIFT))) >>> 6;
            delta = clamp(delta, longint'(DLT_MIN), longint'(DLT_MAX));
            dsum  = hist_one[a] + hist_two[a] + delta;
            hist_two[a] = hist_one[a];
            hist_one[a] = delta;
            dterm = (dsum * kd) >>> 8;

            drv = clamp(pterm + iterm + dterm, longint'(DRV_MIN), longint'(DRV_MAX));
            exp_d.axis  = a[1:0];
            exp_d.drive = drv[15:0];
            expected_drives.push_back(exp_d);
        endfunction

        task check_drive(input logic [1:0] axis, input logic signed [15:0] drive);
            drive_t exp_d;
            if (expected_drives.size() == 0) begin
                report($sformatf("drive %0d on axis %0d with none outstanding", drive, axis));
            end else begin
                exp_d = expected_drives.pop_front();
                if (axis !== exp_d.axis || drive !== exp_d.drive)
                    report($sformatf("axis %0d drive %0d, want axis %0d drive %0d",
                                     axis, drive, exp_d.axis, exp_d.drive));
            end
        endtask

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_axis_index     = '0;
    logic signed [9:0]     i_stick_command  = '0;
    logic signed [15:0]    i_gyro_rate      = '0;
    logic signed [11:0]    i_attitude_angle = '0;
    logic [15:0]           i_loop_time      = '0;
    logic [1:0]            i_flight_mode    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall      = 1'b0;
    logic [1:0]            o_out_axis;
    logic signed [15:0]    o_drive_value;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_W-1:0]      i_cfg_data       = '0;

    int           in_idle_pct  = 0;
    int           out_idle_pct = 0;
    drive_checker drives;

    rate_pid_three_axis u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_axis_index     (i_axis_index),
        .i_stick_command  (i_stick_command),
        .i_gyro_rate      (i_gyro_rate),
        .i_attitude_angle (i_attitude_angle),
        .i_loop_time      (i_loop_time),
        .i_flight_mode    (i_flight_mode),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_axis       (o_out_axis),
        .o_drive_value    (o_drive_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Result side: check every accepted drive value, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            drives.check_drive(o_out_axis, o_drive_value);
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Present one request, idling first at random, and return once it is taken
    task automatic send_sample(input logic [1:0] ax, input logic [9:0] st,
                               input logic [15:0] gy, input logic [11:0] ang,
                               input logic [15:0] lt, input logic [1:0] md);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_axis_index     <= ax;
        i_stick_command  <= st;
        i_gyro_rate      <= gy;
        i_attitude_angle <= ang;
        i_loop_time      <= lt;
        i_flight_mode    <= md;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        drives.note_sample(ax, st, gy, ang, lt, md);
    endtask

    task automatic random_sample();
        logic [1:0]  ax, md;
        logic [9:0]  st;
        logic [15:0] gy, lt;
        logic [11:0] ang;
        ax = ($urandom_range(19) == 0) ? AXIS_AS_YAW : 2'($urandom_range(2));
        md = ($urandom_range(19) == 0) ? MODE_AS_ACRO : 2'($urandom_range(2));
        st = 10'($urandom());
        // gyro mostly within -2000..2000 so the terms stay out of saturation
        gy = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(4000) - 2000);
        ang = ($urandom_range(9) == 0) ? 12'($urandom()) : 12'($urandom_range(3600) - 1800);
        case ($urandom_range(9))
            0:       lt = 16'($urandom_range(15));
            1:       lt = 16'($urandom());
            default: lt = 16'($urandom_range(5000, 500));
        endcase
        send_sample(ax, st, gy, ang, lt, md);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        drives.write_reg(idx, data);
    endtask

    // Write every register, plus one index that maps to nothing
    task automatic apply_settings(input logic [23:0] g_roll, input logic [23:0] g_pitch,
                                  input logic [23:0] g_yaw, input logic [15:0] lvl,
                                  input logic [23:0] rates, input logic [31:0] trims);
        put_reg(CFG_GAINS_ROLL,  CFG_W'(g_roll));
        put_reg(CFG_GAINS_PITCH, CFG_W'(g_pitch));
        put_reg(CFG_GAINS_YAW,   CFG_W'(g_yaw));
        put_reg(CFG_LEVEL_GAINS, CFG_W'(lvl));
        put_reg(CFG_STICK_RATES, CFG_W'(rates));
        put_reg(CFG_LEVEL_TRIMS, trims);
        put_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_settings();
        apply_settings(24'($urandom()), 24'($urandom()), 24'($urandom()), 16'($urandom()),
                       24'($urandom()),
                       {16'($urandom_range(600) - 300), 16'($urandom_range(600) - 300)});
    endtask

    // Wait for every owed drive value, then let the pipeline run dry
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (drives.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        drives = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, every mode and axis, short loop times
        send_sample(AXIS_ROLL,   10'sd511,  16'sd0,      12'sd0,     16'd1000, MODE_ACRO);
        send_sample(AXIS_PITCH, -10'sd512,  16'sd0,      12'sd1800,  16'd1000, MODE_ANGLE);
        send_sample(AXIS_ROLL,   10'sd300,  16'sd1000,  -12'sd1800,  16'd2000, MODE_HORIZON);
        send_sample(AXIS_YAW,   -10'sd300, -16'sd500,    12'sd0,     16'd2500, MODE_ACRO);
        send_sample(AXIS_AS_YAW, 10'sd200,  16'sd32767,  12'sd0,     16'd2500, MODE_ACRO);
        send_sample(AXIS_ROLL,  -10'sd200, -16'sd32768,  12'sd0,     16'd0,    MODE_AS_ACRO);
        send_sample(AXIS_PITCH,  10'sd50,   16'sd100,    12'sd20,    16'd15,   MODE_ACRO);
        send_sample(AXIS_PITCH,  10'sd50,   16'sd100,    12'sd20,    16'd16,   MODE_ACRO);
        // integrator driven into its upper clamp, then a full-swing delta
        send_sample(AXIS_ROLL,   10'sd0,   -16'sd32768,  12'sd0,     16'd65535, MODE_ACRO);
        send_sample(AXIS_ROLL,   10'sd0,   -16'sd32768,  12'sd0,     16'd65535, MODE_ACRO);
        send_sample(AXIS_ROLL,   10'sd0,    16'sd32767,  12'sd0,     16'd16,   MODE_ACRO);
        send_sample(AXIS_ROLL,   10'sd0,   -16'sd32768,  12'sd0,     16'd16,   MODE_ACRO);

        settle();
        apply_settings(24'h171E28, 24'h0F2840, 24'h052D55, 16'hFF40, 24'h405060,
                       {16'hFF06, 16'h00FA});
        send_sample(AXIS_ROLL,   10'sd511,  16'sd0,      12'sd0,     16'd1000, MODE_ACRO);
        send_sample(AXIS_PITCH, -10'sd512,  16'sd0,      12'sd0,     16'd1000, MODE_ACRO);
        send_sample(AXIS_YAW,    10'sd511,  16'sd0,      12'sd0,     16'd1000, MODE_ANGLE);
        send_sample(AXIS_ROLL,   10'sd500,  16'sd0,     -12'sd1800,  16'd1000, MODE_ANGLE);
        send_sample(AXIS_PITCH, -10'sd511,  16'sd0,      12'sd1800,  16'd1000, MODE_HORIZON);
        send_sample(AXIS_ROLL,   10'sd511,  16'sd0,      12'sd0,     16'd1000, MODE_ANGLE);
        send_sample(AXIS_PITCH, -10'sd512,  16'sd0,      12'sd0,     16'd1000, MODE_ANGLE);
        send_sample(AXIS_AS_YAW, 10'sd100,  16'sd0,      12'sd900,   16'd1000, MODE_HORIZON);
        // integrator driven into its lower clamp
        send_sample(AXIS_PITCH,  10'sd0,    16'sd32767,  12'sd0,     16'd65535, MODE_HORIZON);
        send_sample(AXIS_PITCH,  10'sd0,    16'sd32767,  12'sd0,     16'd65535, MODE_HORIZON);

        // random blocks: sender-light idling, receiver-light idling, then none
        for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
            settle();
            case (blk)
                1:       apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF,
                                        24'hFFFFFF, 32'h8000_7FFF);
                3:       apply_settings(24'h000000, 24'h000000, 24'h000000, 16'h0000,
                                        24'h000000, 32'h7FFF_8000);
                default: random_settings();
            endcase
            in_idle_pct  = (blk < 2) ? 29 : ((blk < 4) ? 82 : 0);
            out_idle_pct = (blk < 2) ? 82 : ((blk < 4) ? 29 : 0);
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                // hold the sender back once until the block has drained
                if (blk == 0 && k == BLOCK_ITEMS / 2) begin
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (drives.pending() != 0);
                end
                random_sample();
            end
        end

        settle();
        if (drives.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #(20 * 400000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== rate_pid_three_axis.f =====
rtl/rpid_pkg.sv
rtl/rpid_div.sv
rtl/rate_pid_three_axis.sv
sim/tb.sv
